// ----- hdl/assert_macros.svh -----
// Assertion macros for the checks of the frame codec, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XFC_ASSERT_SAME(label, clk, rst_n, cond, expect_true) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_true)) \
    else $error("frame codec check failed");

// Next-cycle implication, checked outside reset.
`define XFC_ASSERT_NEXT(label, clk, rst_n, cond, expect_true) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_true)) \
    else $error("frame codec check failed");

`endif

// ----- hdl/xfc_pkg.sv -----
// Package: payload types, result jobs and codes of the frame codec.
`timescale 1ns / 1ps

package xfc_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] command_length;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] error_code;
  } out_t;

  // Up to four results caused by one accepted byte, in delivery order.
  typedef struct packed {
    logic [2:0]     count;
    out_t [3:0]     res;
  } job_t;

  localparam logic [1:0] KindFrame   = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindVerdict = 2'd2;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrShort    = 3'd1;
  localparam logic [2:0] ErrMismatch = 3'd2;
  localparam logic [2:0] ErrDevice   = 3'd3;
  localparam logic [2:0] ErrChecksum = 3'd4;

  localparam logic       FuncFrame  = 1'b0;
  localparam logic       FuncAnswer = 1'b1;

  localparam logic [7:0] BroadcastAddr = 8'hFF;
  localparam logic [7:0] CmdAnyStatus  = 8'h11;
  localparam logic [7:0] StatusOk      = 8'h01;
  localparam logic [7:0] StatusNone    = 8'h00;
  localparam logic [7:0] LenOverhead   = 8'd3;
  localparam logic [7:0] MinAnswerLen  = 8'd5;

  localparam logic [7:0] PosCommand = 8'd2;
  localparam logic [7:0] PosStatus  = 8'd3;
  localparam logic [7:0] PosPayload = 8'd4;

  localparam int         AddrW = 3;
  localparam logic [AddrW-1:0] RegReaderAddress = 3'd0;

endpackage

// ----- hdl/xfc_front.sv -----
// Front end: accepts bytes, tracks frame and answer progress, builds result jobs.
`timescale 1ns / 1ps

module xfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  xfc_pkg::in_t      in_data,
  input  logic [7:0]        reader_address,
  input  logic              q_full,
  output logic              push,
  output xfc_pkg::job_t     job
);

  logic [7:0] last_cmd_r, last_cmd_nxt;
  logic [7:0] frame_pos_r, frame_pos_nxt;
  logic [7:0] frame_xor_r, frame_xor_nxt;
  logic [7:0] ans_pos_r, ans_pos_nxt;
  logic [7:0] ans_len_r, ans_len_nxt;
  logic [7:0] ans_xor_r, ans_xor_nxt;
  logic [7:0] ans_status_r, ans_status_nxt;
  logic [2:0] ans_err_r, ans_err_nxt;

  logic       accept;
  logic [7:0] len;
  logic [7:0] len_byte;
  logic [7:0] pos_inc;
  logic [7:0] xor_base;
  logic [7:0] xor_new;
  logic [2:0] err_final;

  function automatic xfc_pkg::out_t mk_result(input logic [1:0] kind, input logic [7:0] b,
                                              input logic last, input logic [2:0] err);
    xfc_pkg::out_t r;
    r.kind       = kind;
    r.out_byte   = b;
    r.last       = last;
    r.error_code = err;
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (job.count != 3'd0);

  // A zero command length behaves as a length of one.
  assign len      = (in_data.command_length == 8'd0) ? 8'd1 : in_data.command_length;
  assign len_byte = len + xfc_pkg::LenOverhead;
  assign pos_inc  = frame_pos_r + 8'd1;

  always_comb begin
    last_cmd_nxt   = last_cmd_r;
    frame_pos_nxt  = frame_pos_r;
    frame_xor_nxt  = frame_xor_r;
    ans_pos_nxt    = ans_pos_r;
    ans_len_nxt    = ans_len_r;
    ans_xor_nxt    = ans_xor_r;
    ans_status_nxt = ans_status_r;
    ans_err_nxt    = ans_err_r;
    job            = '0;
    xor_base       = frame_xor_r;
    xor_new        = frame_xor_r;
    err_final      = ans_err_r;
    if (accept) begin
      if (in_data.func == xfc_pkg::FuncFrame) begin
        if (frame_pos_r == 8'd0) begin
          job.res[0]   = mk_result(xfc_pkg::KindFrame, len_byte, 1'b0, xfc_pkg::ErrNone);
          job.res[1]   = mk_result(xfc_pkg::KindFrame, reader_address, 1'b0,
                                   xfc_pkg::ErrNone);
          job.res[2]   = mk_result(xfc_pkg::KindFrame, in_data.data_byte, 1'b0,
                                   xfc_pkg::ErrNone);
          job.count    = 3'd3;
          xor_base     = len_byte ^ reader_address;
          last_cmd_nxt = in_data.data_byte;
        end else begin
          job.res[0] = mk_result(xfc_pkg::KindFrame, in_data.data_byte, 1'b0,
                                 xfc_pkg::ErrNone);
          job.count  = 3'd1;
        end
        xor_new = xor_base ^ in_data.data_byte;
        if (pos_inc >= len) begin
          job.res[job.count[1:0]] = mk_result(xfc_pkg::KindFrame, xor_new, 1'b1,
                                              xfc_pkg::ErrNone);
          job.count     = job.count + 3'd1;
          frame_pos_nxt = 8'd0;
          frame_xor_nxt = 8'd0;
        end else begin
          frame_pos_nxt = pos_inc;
          frame_xor_nxt = xor_new;
        end
      end else if (ans_pos_r == 8'd0) begin
        // Length byte of a new answer.
        ans_len_nxt    = in_data.data_byte;
        ans_status_nxt = 8'd0;
        ans_err_nxt    = xfc_pkg::ErrNone;
        if (in_data.data_byte < xfc_pkg::MinAnswerLen) begin
          ans_xor_nxt = 8'd0;
          job.res[0]  = mk_result(xfc_pkg::KindVerdict, 8'd0, 1'b1, xfc_pkg::ErrShort);
          job.count   = 3'd1;
        end else begin
          ans_xor_nxt = in_data.data_byte;
          ans_pos_nxt = 8'd1;
        end
      end else if (({1'b0, ans_pos_r} + 9'd1) >= {1'b0, ans_len_r}) begin
        // Checksum byte closes the answer.
        if (ans_err_r == xfc_pkg::ErrNone && in_data.data_byte != ans_xor_r) begin
          err_final = xfc_pkg::ErrChecksum;
        end
        ans_err_nxt = err_final;
        job.res[0]  = mk_result(xfc_pkg::KindVerdict, ans_status_r, 1'b1, err_final);
        job.count   = 3'd1;
        ans_pos_nxt = 8'd0;
        ans_xor_nxt = 8'd0;
      end else begin
        ans_xor_nxt = ans_xor_r ^ in_data.data_byte;
        if (ans_pos_r == xfc_pkg::PosCommand) begin
          if (ans_err_r == xfc_pkg::ErrNone && in_data.data_byte != last_cmd_r) begin
            ans_err_nxt = xfc_pkg::ErrMismatch;
          end
        end else if (ans_pos_r == xfc_pkg::PosStatus) begin
          ans_status_nxt = in_data.data_byte;
          if (ans_err_r == xfc_pkg::ErrNone && last_cmd_r != xfc_pkg::CmdAnyStatus &&
              in_data.data_byte != xfc_pkg::StatusOk &&
              in_data.data_byte != xfc_pkg::StatusNone) begin
            ans_err_nxt = xfc_pkg::ErrDevice;
          end
        end else if (ans_pos_r >= xfc_pkg::PosPayload) begin
          job.res[0] = mk_result(xfc_pkg::KindPayload, in_data.data_byte, 1'b0,
                                 xfc_pkg::ErrNone);
          job.count  = 3'd1;
        end
        ans_pos_nxt = ans_pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_r   <= 8'd0;
      frame_pos_r  <= 8'd0;
      frame_xor_r  <= 8'd0;
      ans_pos_r    <= 8'd0;
      ans_len_r    <= 8'd0;
      ans_xor_r    <= 8'd0;
      ans_status_r <= 8'd0;
      ans_err_r    <= xfc_pkg::ErrNone;
    end else begin
      last_cmd_r   <= last_cmd_nxt;
      frame_pos_r  <= frame_pos_nxt;
      frame_xor_r  <= frame_xor_nxt;
      ans_pos_r    <= ans_pos_nxt;
      ans_len_r    <= ans_len_nxt;
      ans_xor_r    <= ans_xor_nxt;
      ans_status_r <= ans_status_nxt;
      ans_err_r    <= ans_err_nxt;
    end
  end

endmodule

// ----- hdl/xfc_queue.sv -----
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module xfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xfc_pkg::job_t wr_data,
  input  logic          pop,
  output xfc_pkg::job_t rd_data,
  output logic          full,
  output logic          not_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  xfc_pkg::job_t mem [DEPTH];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/xfc_back.sv -----
// Back end: walks the results of the head job into the registered output.
`timescale 1ns / 1ps

module xfc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  xfc_pkg::job_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output xfc_pkg::out_t out_data
);

  logic [1:0]    idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  xfc_pkg::out_t out_data_r;
  logic          fire;
  logic          last_slot;

  assign fire      = head_valid && (!out_valid_r || !out_stall);
  assign last_slot = ({1'b0, idx_r} == (head.count - 3'd1));
  assign pop       = fire && last_slot;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_slot ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= head.res[idx_r];
    end
  end

endmodule

// ----- hdl/xor_checked_frame_codec.sv -----
// Top level of the length-prefixed frame codec with XOR checksum.
// Input channel (in_valid, in_stall, in_data): one byte per transfer. With func
// clear the byte is a command byte to be framed; the first byte of a command
// yields a length byte, the reader address and the byte, later bytes pass
// through, and the final byte is followed by the XOR checksum (last set).
// With func set the byte belongs to a received answer; payload bytes are passed
// on and the answer ends in a verdict transfer carrying the status and error.
// Output channel (out_valid, out_stall, out_data): one result per transfer.
// A byte's job enters the queue when the byte is taken; the back end then loads
// the job's first result into the output register. Bytes are taken one per cycle
// while the queue is not full, which holds while each byte causes at most one
// result and out_stall is low; the output delivers one result per cycle. A frame's
// first byte causes three results (four for a one-byte command), the last two.
// A queue of QUEUE_DEPTH jobs lets the front keep taking bytes while the output
// is stalled; in_stall rises only once that queue is full. A stalled result
// holds on the output register until the receiver takes it.
// reader_address is written over the APB-style port at byte address 0 and reads
// back there. Reset clears all frame and answer progress and sets the address
// to the broadcast value.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xor_checked_frame_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  xfc_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output xfc_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xfc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [7:0]    reader_address_r, reader_address_nxt;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  xfc_pkg::job_t job_in;
  xfc_pkg::job_t job_head;
  logic          reg_hit;

  // Configuration register: written in the access phase, read back combinationally.
  assign pready  = 1'b1;
  assign reg_hit = (paddr == xfc_pkg::RegReaderAddress);
  assign prdata  = reg_hit ? {24'd0, reader_address_r} : 32'd0;

  always_comb begin
    reader_address_nxt = reader_address_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      reader_address_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reader_address_r <= xfc_pkg::BroadcastAddr;
    end else begin
      reader_address_r <= reader_address_nxt;
    end
  end

  xfc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .reader_address (reader_address_r),
    .q_full         (q_full),
    .push           (push),
    .job            (job_in)
  );

  xfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (job_in),
    .pop       (pop),
    .rd_data   (job_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  xfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (job_head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Every verdict closes an answer.
  `XFC_ASSERT_SAME(a_verdict_last, clk, rst_n,
                   out_valid && out_data.kind == xfc_pkg::KindVerdict, out_data.last)
  // Only verdicts carry an error code.
  `XFC_ASSERT_SAME(a_err_only_verdict, clk, rst_n,
                   out_valid && out_data.kind != xfc_pkg::KindVerdict,
                   out_data.error_code == xfc_pkg::ErrNone)
  // A byte that causes results leaves a job waiting for the back end.
  `XFC_ASSERT_NEXT(a_push_lands, clk, rst_n, push, q_not_empty)
  // The back end never takes a job from an empty queue.
  `XFC_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, q_not_empty)

endmodule

// ----- test/xfc_checker.sv -----
// Checker for the frame codec: watches both channels and the register port, predicts, compares.
`timescale 1ns / 1ps

module xfc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  xfc_pkg::in_t              in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  xfc_pkg::out_t             out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [xfc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output int                        fail_count,
  output int                        pending_count
);
  import xfc_pkg::*;

  // Mirror of the codec's registers and progress.
  logic [7:0] reader_addr;
  logic [7:0] command_code;
  logic [7:0] frame_pos;
  logic [7:0] frame_sum;
  logic [7:0] answer_pos;
  logic [7:0] answer_len;
  logic [7:0] answer_sum;
  logic [7:0] answer_status;
  logic [2:0] answer_err;

  out_t due_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic flag_fault(input string what);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  task automatic due(input logic [1:0] kind, input logic [7:0] value, input logic last,
                     input logic [2:0] err);
    out_t r;
    r.kind       = kind;
    r.out_byte   = value;
    r.last       = last;
    r.error_code = err;
    due_results.insert(due_results.size(), r);
  endtask

  // Works out every result that one accepted byte causes.
  task automatic frame_or_check(input in_t item);
    logic [7:0] eff_len;
    logic [7:0] len_byte;
    logic [7:0] b;
    b       = item.data_byte;
    eff_len = (item.command_length == 8'd0) ? 8'd1 : item.command_length;
    if (item.func == FuncFrame) begin
      if (frame_pos == 8'd0) begin
        len_byte = eff_len + LenOverhead;
        due(KindFrame, len_byte, 1'b0, ErrNone);
        due(KindFrame, reader_addr, 1'b0, ErrNone);
        frame_sum    = len_byte ^ reader_addr;
        command_code = b;
      end
      due(KindFrame, b, 1'b0, ErrNone);
      frame_sum = frame_sum ^ b;
      frame_pos = frame_pos + 8'd1;
      if (frame_pos >= eff_len) begin
        due(KindFrame, frame_sum, 1'b1, ErrNone);
        frame_pos = 8'd0;
        frame_sum = 8'd0;
      end
    end else if (answer_pos == 8'd0) begin
      answer_len    = b;
      answer_sum    = b;
      answer_status = StatusNone;
      answer_err    = ErrNone;
      if (b < MinAnswerLen) begin
        answer_sum = 8'd0;
        due(KindVerdict, 8'd0, 1'b1, ErrShort);
      end else begin
        answer_pos = 8'd1;
      end
    end else if ({1'b0, answer_pos} + 9'd1 >= {1'b0, answer_len}) begin
      if (answer_err == ErrNone && b != answer_sum) begin
        answer_err = ErrChecksum;
      end
      due(KindVerdict, answer_status, 1'b1, answer_err);
      answer_pos = 8'd0;
      answer_sum = 8'd0;
    end else begin
      answer_sum = answer_sum ^ b;
      if (answer_pos == PosCommand) begin
        if (answer_err == ErrNone && b != command_code) begin
          answer_err = ErrMismatch;
        end
      end else if (answer_pos == PosStatus) begin
        answer_status = b;
        if (answer_err == ErrNone && command_code != CmdAnyStatus &&
            b != StatusOk && b != StatusNone) begin
          answer_err = ErrDevice;
        end
      end else if (answer_pos >= PosPayload) begin
        due(KindPayload, b, 1'b0, ErrNone);
      end
      answer_pos = answer_pos + 8'd1;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      reader_addr   = BroadcastAddr;
      command_code  = 8'd0;
      frame_pos     = 8'd0;
      frame_sum     = 8'd0;
      answer_pos    = 8'd0;
      answer_len    = 8'd0;
      answer_sum    = 8'd0;
      answer_status = 8'd0;
      answer_err    = ErrNone;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegReaderAddress) begin
        reader_addr = pwdata[7:0];
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (due_results.size() == 0) begin
          flag_fault($sformatf("unexpected result %h", out_data));
        end else begin
          want = due_results.pop_front();
          if (out_data.kind !== want.kind) begin
            flag_fault($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
          end
          if (out_data.out_byte !== want.out_byte) begin
            flag_fault($sformatf("out_byte %h, want %h", out_data.out_byte, want.out_byte));
          end
          if (out_data.last !== want.last) begin
            flag_fault($sformatf("last %b, want %b", out_data.last, want.last));
          end
          if (out_data.error_code !== want.error_code) begin
            flag_fault($sformatf("error_code %0d, want %0d", out_data.error_code,
                                 want.error_code));
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        frame_or_check(in_data);
      end
    end
    pending_count = due_results.size();
  end

endmodule

// ----- test/tb_xor_checked_frame_codec.sv -----
// Testbench top for the frame codec: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_xor_checked_frame_codec;
  import xfc_pkg::*;

  // Generous ceiling on the run. The slowest correct run is far below this: every
  // byte waiting out a sender gap and up to four results each waiting out a stall.
  localparam int CycleLimit = 300000;
  // Length of the one long hold-off of the receiver, enough to fill the job queue.
  localparam int LongHold   = 80;
  // Cycles allowed after the last result for bytes that cause none to settle.
  localparam int SettleCycles = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  // Stimulus bookkeeping. The top follows frame and answer progress only so far as
  // it needs to start well-formed sequences and to echo the right command code.
  int         items_sent = 0;
  int         frame_taken = 0;
  logic [7:0] frame_code = 8'd0;
  int         answer_taken = 0;
  int         answer_len = 0;

  // Idling controls for the sending side and the receiving side.
  bit sender_idles = 1'b0;
  bit receiver_idles = 1'b0;
  bit hold_off_pending = 1'b0;

  always #1 clk = ~clk;

  xor_checked_frame_codec uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  xfc_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // The run is ended here if the codec stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("xor_checked_frame_codec: mismatch");
      $finish;
    end
  end

  // Receiving side. Stalls come in short random bursts while receiver_idles is set.
  // When the top asks for a hold-off, stall is held high for the long hold-off
  // counted here against LongHold, so the job queue fills and the codec stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one byte and returns once its transfer has taken place. Valid stays
  // high into the next call unless that call opens an idle gap.
  task automatic send_item(input logic func, input logic [7:0] data, input logic [7:0] len);
    in_t        item;
    logic [7:0] eff_len;
    item.func           = func;
    item.data_byte      = data;
    item.command_length = len;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    eff_len = (len == 8'd0) ? 8'd1 : len;
    if (func == FuncFrame) begin
      if (frame_taken == 0) begin
        frame_code = data;
      end
      frame_taken++;
      if (frame_taken >= eff_len) begin
        frame_taken = 0;
      end
    end else if (answer_taken == 0) begin
      if (data >= MinAnswerLen) begin
        answer_len   = int'(data);
        answer_taken = 1;
      end
    end else if (answer_taken + 1 >= answer_len) begin
      answer_taken = 0;
    end else begin
      answer_taken++;
    end
  endtask

  // Closes any frame left open by stray bytes: a length of one ends it at once.
  task automatic finish_frame();
    while (frame_taken != 0) begin
      send_item(FuncFrame, 8'($urandom_range(0, 255)), 8'd1);
    end
  endtask

  // Runs out any answer left half-way with random bytes, a broken answer.
  task automatic finish_answer();
    while (answer_taken != 0) begin
      send_item(FuncAnswer, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_command(input logic [7:0] len, input logic [7:0] first);
    finish_frame();
    for (int i = 0; i < len; i++) begin
      send_item(FuncFrame, (i == 0) ? first : 8'($urandom_range(0, 255)), len);
    end
  endtask

  // A whole answer: length byte, address, echoed code, status, payload, checksum.
  // With spoil set one bit of the checksum is turned over.
  task automatic send_answer(input int total, input logic [7:0] code,
                             input logic [7:0] status, input bit spoil);
    logic [7:0] sum;
    logic [7:0] b;
    finish_answer();
    sum = total[7:0];
    send_item(FuncAnswer, total[7:0], 8'($urandom_range(0, 255)));
    b = 8'($urandom_range(0, 255));
    sum = sum ^ b;
    send_item(FuncAnswer, b, 8'($urandom_range(0, 255)));
    sum = sum ^ code;
    send_item(FuncAnswer, code, 8'($urandom_range(0, 255)));
    sum = sum ^ status;
    send_item(FuncAnswer, status, 8'($urandom_range(0, 255)));
    for (int i = 5; i < total; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      send_item(FuncAnswer, b, 8'($urandom_range(0, 255)));
    end
    if (spoil) begin
      sum = sum ^ (8'd1 << $urandom_range(0, 7));
    end
    send_item(FuncAnswer, sum, 8'($urandom_range(0, 255)));
  endtask

  // Lowers valid and waits until every predicted result has been taken, then lets
  // the pipeline settle for bytes that cause no result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // A register write: setup cycle, then access cycle until pready.
  task automatic write_reader_address(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegReaderAddress;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed commands and answers with random content, the rest short
  // answers and stray bytes of either kind.
  task automatic random_traffic(input int upto, input bit idles);
    int         len;
    logic [7:0] status;
    logic [7:0] code;
    while (items_sent < upto) begin
      sender_idles   = idles && ($urandom_range(0, 3) != 0);
      receiver_idles = idles && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          code = ($urandom_range(0, 4) == 0) ? CmdAnyStatus : 8'($urandom_range(0, 255));
          send_command(8'(len), code);
        end
        4, 5, 6: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(5, 12);
          case ($urandom_range(0, 5))
            0: begin
              status = 8'($urandom_range(0, 255));
            end
            1, 2: begin
              status = StatusNone;
            end
            default: begin
              status = StatusOk;
            end
          endcase
          code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : frame_code;
          send_answer(len, code, status, $urandom_range(0, 7) == 0);
        end
        7: begin
          finish_answer();
          send_item(FuncAnswer, 8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
        end
        8: begin
          repeat ($urandom_range(1, 4)) begin
            send_item(FuncAnswer, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
        end
        default: begin
          len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 255);
          send_item(FuncFrame, 8'($urandom_range(0, 255)), 8'(len));
        end
      endcase
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_n    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the address still at its broadcast reset value.
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    // One-byte command, then a clean answer with no payload.
    send_command(8'd1, 8'h00);
    send_answer(5, 8'h00, StatusOk, 1'b0);
    // Length bytes below the minimum give an immediate short verdict.
    send_item(FuncAnswer, 8'h04, 8'hFF);
    send_item(FuncAnswer, 8'h00, 8'h00);
    // A zero command length is taken as one, and this code accepts any status.
    send_item(FuncFrame, CmdAnyStatus, 8'h00);
    send_answer(6, CmdAnyStatus, 8'hFF, 1'b0);
    // An oversized length wraps the length byte; a shorter length on the next
    // byte ends the frame early.
    send_item(FuncFrame, 8'hFF, 8'hFF);
    send_item(FuncFrame, 8'h80, 8'h01);
    send_item(FuncFrame, 8'h7E, 8'd252);
    send_item(FuncFrame, 8'h01, 8'd2);
    // Wrong echoed code, bad status and bad checksum together: the mismatch wins.
    send_answer(5, 8'h00, 8'h02, 1'b1);
    drain();

    // First random phase, starting with a long hold-off of the receiver while
    // the sender keeps offering transfers.
    write_reader_address(8'h00);
    hold_off_pending = 1'b1;
    random_traffic(110, 1'b1);
    drain();

    write_reader_address(8'($urandom_range(1, 254)));
    random_traffic(190, 1'b1);
    drain();

    // Last part: back to the broadcast address and no idling on either side.
    write_reader_address(BroadcastAddr);
    random_traffic(260, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("xor_checked_frame_codec: match");
    end else begin
      $display("xor_checked_frame_codec: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/xfc_pkg.sv
hdl/xfc_front.sv
hdl/xfc_queue.sv
hdl/xfc_back.sv
hdl/xor_checked_frame_codec.sv
test/xfc_checker.sv
test/tb_xor_checked_frame_codec.sv
